// ----- hdl/rolling_hash_pattern_matcher_top_defines.svh -----
// Assertion macros shared by the rolling hash pattern matcher RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ROLLING_HASH_PATTERN_MATCHER_TOP_DEFINES_SVH
`define ROLLING_HASH_PATTERN_MATCHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent and consequent in the same cycle.
`define RHPM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhpm: same-cycle check failed");
// Consequent in the cycle after the antecedent.
`define RHPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhpm: next-cycle check failed");
`else
`define RHPM_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define RHPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/rhpm_pkg.sv -----
// Shared constants, types and hash helper functions of the pattern matcher.
// Depends on nothing; used by the channel interfaces and the top level.
package rhpm_pkg;

   localparam int MAX_PATTERN_DEF  = 16;
   localparam int WINDOW_DEPTH_DEF = 16;
   localparam int BYTE_W           = 8;
   localparam int VALUE_W          = 32;
   localparam int HASH_W           = 26;
   localparam int LEN_W            = 5;
   localparam int CSR_W            = 64;
   localparam int CSR_IDX_W        = 2;
   localparam int PAT_BYTES        = 16;

   localparam logic KIND_HASH = 1'b0;
   localparam logic KIND_POS  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_PATTERN_LOW    = 2'd1,
      CSR_PATTERN_HIGH   = 2'd2
   } csr_index_type;

   // Byte modulo 3: base-4 digits all weigh 1 modulo 3, so fold them first.
   function automatic logic [1:0] mod3(input logic [BYTE_W-1:0] x);
      logic [3:0] s;
      logic [1:0] r;
      s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
      case (s) inside
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
         4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
         default:                       r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [HASH_W-1:0] pow3(input logic [3:0] e);
      logic [HASH_W-1:0] p;
      unique case (e)
         4'd0:  p = 26'd1;
         4'd1:  p = 26'd3;
         4'd2:  p = 26'd9;
         4'd3:  p = 26'd27;
         4'd4:  p = 26'd81;
         4'd5:  p = 26'd243;
         4'd6:  p = 26'd729;
         4'd7:  p = 26'd2187;
         4'd8:  p = 26'd6561;
         4'd9:  p = 26'd19683;
         4'd10: p = 26'd59049;
         4'd11: p = 26'd177147;
         4'd12: p = 26'd531441;
         4'd13: p = 26'd1594323;
         4'd14: p = 26'd4782969;
         4'd15: p = 26'd14348907;
      endcase
      return p;
   endfunction

   // A digit of 0, 1 or 2 times its power of three.
   function automatic logic [HASH_W-1:0] weigh(input logic [1:0] d,
                                               input logic [HASH_W-1:0] p);
      logic [HASH_W-1:0] t;
      case (d)
         2'd1:    t = p;
         2'd2:    t = p << 1;
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [BYTE_W-1:0] pat_byte(input logic [CSR_W-1:0] lo,
                                                  input logic [CSR_W-1:0] hi,
                                                  input logic [3:0] idx);
      logic [2*CSR_W-1:0] all;
      all = {hi, lo};
      return all[8*idx +: BYTE_W];
   endfunction

endpackage

// ----- hdl/rhpm_channels.sv -----
// Valid/ready channel interfaces for text bytes in and result words out.
// Depends on rhpm_pkg for the field widths.
interface rhpm_req_if import rhpm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface rhpm_rsp_if import rhpm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [VALUE_W-1:0] value;
   logic               last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink (input valid, input kind, input value, input last, output ready);
endinterface

// ----- hdl/rolling_hash_pattern_matcher_top.sv -----
// Top level of the base-3 rolling hash pattern matcher.
// Depends on rhpm_pkg, rhpm_channels, rhpm_ram and the assertion macro header.
//
// Text bytes arrive one word at a time on req_chan and are written into a ring
// RAM of WINDOW_DEPTH entries, while their base-3 digits (byte modulo 3) shift
// through a line of MAX_PATTERN registers. For each byte, the accept cycle
// forms partial hash sums of the window and of the configured pattern, and the
// ST_TOTAL state then adds them, emits the pattern hash (only after the very
// first byte) and compares the two hashes. On a hit, once pattern_length
// bytes have arrived, the window is walked through the single RAM read port
// from its oldest byte, one ring entry and one position word per cycle while
// rsp_chan takes the words, stopping after the first mismatch or the last
// pattern byte. No new byte is taken until the block is back in ST_IDLE.
// Results leave through an output register. Configuration is written through
// csr_we, csr_index and csr_wdata; writes to an index beyond the register list
// are dropped, and registers must only change while the block is idle.
`include "rolling_hash_pattern_matcher_top_defines.svh"

module rolling_hash_pattern_matcher_top import rhpm_pkg::*; #(
   parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   rhpm_req_if.sink             req_chan,
   rhpm_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int KW = $clog2(MAX_PATTERN + 1);
   localparam int NG = (MAX_PATTERN + 3) / 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_WALK
   } state_type;

   // Configuration registers.
   logic [LEN_W-1:0] pat_len_ff, pat_len_in;
   logic [CSR_W-1:0] pat_lo_ff, pat_lo_in;
   logic [CSR_W-1:0] pat_hi_ff, pat_hi_in;

   // Control and datapath registers.
   state_type          state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [VALUE_W-1:0] count_ff, count_in;
   logic               reported_ff, reported_in;
   logic [1:0]         dig_ff [MAX_PATTERN];
   logic [1:0]         dig_in [MAX_PATTERN];
   logic [KW-1:0]      n_ff, n_in;
   logic [HASH_W-1:0]  wpart_ff [NG];
   logic [HASH_W-1:0]  wpart_in [NG];
   logic [HASH_W-1:0]  ppart_ff [NG];
   logic [HASH_W-1:0]  ppart_in [NG];
   logic [KW-1:0]      k_ff, k_in;
   logic [VALUE_W-1:0] pos_ff, pos_in;
   logic [AW-1:0]      addr_ff, addr_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic [KW-1:0]      len_eff;
   logic               accept;
   logic               slot_free;
   logic [HASH_W-1:0]  w_term [MAX_PATTERN];
   logic [HASH_W-1:0]  p_term [MAX_PATTERN];
   logic [HASH_W-1:0]  whash;
   logic [HASH_W-1:0]  phash;
   logic               hit;
   logic [AW-1:0]      start_addr;
   logic [AW:0]        head_x;
   logic [AW:0]        n_x;
   logic [AW-1:0]      addr_next;
   logic [4:0]         k_ext;
   logic [BYTE_W-1:0]  ring_byte;
   logic               walk_last;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;

   rhpm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (req_chan.text_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ring_byte)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind  = rsp_kind_ff;
   assign rsp_chan.value = rsp_value_ff;
   assign rsp_chan.last  = rsp_last_ff;

   // A length of zero acts as one, and lengths above MAX_PATTERN are clamped.
   always_comb begin
      if (pat_len_ff == '0) begin
         len_eff = KW'(1);
      end else if (pat_len_ff > LEN_W'(MAX_PATTERN)) begin
         len_eff = KW'(MAX_PATTERN);
      end else begin
         len_eff = KW'(pat_len_ff);
      end
   end

   // Digit line after the incoming byte shifts in, and the weighted terms.
   // Digit age a (0 newest) is window byte n-1-a and weighs 3^(n-1-a).
   always_comb begin
      dig_in[0] = accept ? mod3(req_chan.text_byte) : dig_ff[0];
      for (int a = 1; a < MAX_PATTERN; a++) begin
         dig_in[a] = accept ? dig_ff[a-1] : dig_ff[a];
      end
      for (int a = 0; a < MAX_PATTERN; a++) begin
         if (a < int'(len_eff)) begin
            w_term[a] = weigh(dig_in[a], pow3(4'(int'(len_eff) - 1 - a)));
            p_term[a] = weigh(mod3(pat_byte(pat_lo_ff, pat_hi_ff, 4'(a))), pow3(4'(a)));
         end else begin
            w_term[a] = '0;
            p_term[a] = '0;
         end
      end
      for (int g = 0; g < NG; g++) begin
         wpart_in[g] = '0;
         ppart_in[g] = '0;
         for (int j = 0; j < 4; j++) begin
            if (4 * g + j < MAX_PATTERN) begin
               wpart_in[g] = wpart_in[g] + w_term[4*g+j];
               ppart_in[g] = ppart_in[g] + p_term[4*g+j];
            end
         end
      end
   end

   // Second level of the hash sums and the hit decision.
   always_comb begin
      whash = '0;
      phash = '0;
      for (int g = 0; g < NG; g++) begin
         whash = whash + wpart_ff[g];
         phash = phash + ppart_ff[g];
      end
      hit = (count_ff >= VALUE_W'(n_ff)) && (whash == phash);
   end

   // Oldest window entry sits n places behind the write pointer.
   always_comb begin
      head_x = {1'b0, head_ff};
      n_x    = (AW+1)'(n_ff);
      if (head_x >= n_x) begin
         start_addr = AW'(head_x - n_x);
      end else begin
         start_addr = AW'(head_x + (AW+1)'(WINDOW_DEPTH) - n_x);
      end
      addr_next = (addr_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : addr_ff + AW'(1);
      k_ext     = 5'(k_ff);
      walk_last = (ring_byte != pat_byte(pat_lo_ff, pat_hi_ff, k_ext[3:0])) ||
                  (k_ff == KW'(n_ff - KW'(1)));
   end

   // Next-state logic of the sequencer, the configuration port and the output.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      reported_in  = reported_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      addr_in      = addr_ff;
      pat_len_in   = pat_len_ff;
      pat_lo_in    = pat_lo_ff;
      pat_hi_in    = pat_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_next;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LENGTH: pat_len_in = csr_wdata[LEN_W-1:0];
            CSR_PATTERN_LOW:    pat_lo_in  = csr_wdata;
            CSR_PATTERN_HIGH:   pat_hi_in  = csr_wdata;
            default:            ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ram_wr_en = 1'b1;
               head_in   = (head_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : head_ff + AW'(1);
               if (count_ff != '1) begin
                  count_in = count_ff + VALUE_W'(1);
               end
               n_in     = len_eff;
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            // The pattern hash word goes out once, after the first byte.
            if (!reported_ff && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_HASH;
               rsp_value_in = VALUE_W'(phash);
               rsp_last_in  = !hit;
               reported_in  = 1'b1;
            end
            if (reported_ff || slot_free) begin
               if (hit) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = start_addr;
                  addr_in     = start_addr;
                  k_in        = '0;
                  pos_in      = count_ff - VALUE_W'(n_ff) + VALUE_W'(1);
                  state_in    = ST_WALK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK: begin
            // Ring data for position k is in the RAM's read register now.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_POS;
               rsp_value_in = pos_ff;
               rsp_last_in  = walk_last;
               if (walk_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_rd_en = 1'b1;
                  addr_in   = addr_next;
                  k_in      = k_ff + KW'(1);
                  pos_in    = pos_ff + VALUE_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         reported_ff  <= 1'b0;
         n_ff         <= KW'(1);
         k_ff         <= '0;
         pos_ff       <= '0;
         addr_ff      <= '0;
         pat_len_ff   <= LEN_W'(1);
         pat_lo_ff    <= '0;
         pat_hi_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= KIND_HASH;
         rsp_value_ff <= '0;
         rsp_last_ff  <= 1'b0;
         for (int a = 0; a < MAX_PATTERN; a++) begin
            dig_ff[a] <= '0;
         end
         for (int g = 0; g < NG; g++) begin
            wpart_ff[g] <= '0;
            ppart_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         reported_ff  <= reported_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         pos_ff       <= pos_in;
         addr_ff      <= addr_in;
         pat_len_ff   <= pat_len_in;
         pat_lo_ff    <= pat_lo_in;
         pat_hi_ff    <= pat_hi_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_kind_ff  <= rsp_kind_in;
         rsp_value_ff <= rsp_value_in;
         rsp_last_ff  <= rsp_last_in;
         for (int a = 0; a < MAX_PATTERN; a++) begin
            dig_ff[a] <= dig_in[a];
         end
         if (accept) begin
            for (int g = 0; g < NG; g++) begin
               wpart_ff[g] <= wpart_in[g];
               ppart_ff[g] <= ppart_in[g];
            end
         end
      end
   end

   // The walk never runs past the last pattern byte in use.
   `RHPM_ASSERT_SAME(a_walk_in_range, clock, reset, state_ff == ST_WALK, k_ff < n_ff)
   // A walk only starts once a full window has arrived.
   `RHPM_ASSERT_SAME(a_walk_full_window, clock, reset, state_ff == ST_WALK, count_ff >= VALUE_W'(n_ff))
   // A pattern hash word can only be pending once the flag records it.
   `RHPM_ASSERT_SAME(a_hash_flagged, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_HASH), reported_ff)
   // Once reported, the pattern hash is never reported again.
   `RHPM_ASSERT_NEXT(a_hash_sticky, clock, reset, reported_ff, reported_ff)

endmodule

// ----- hdl/rhpm_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module rhpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for rolling_hash_pattern_matcher_top: streams text words,
// predicts pattern hash and compared-position words, and checks each one.
// Depends on rhpm_pkg, the rhpm channel interfaces and the matcher RTL.
module testbench;
   import rhpm_pkg::*;

   // Run shape. The settle figure covers the longest walk of a hash hit plus
   // the accept and total states, so the block is idle before a register changes.
   localparam int          SETTLE_CYCLES = MAX_PATTERN_DEF + 8;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          RANDOM_BYTES  = 440;
   localparam int          RUN_LIMIT     = 1000000;
   localparam int          TX_SIDE       = 0;
   localparam int          RX_SIDE       = 1;
   // The register port has one index past the end of the list; writes there
   // must leave the pattern untouched.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic               kind;
      logic [VALUE_W-1:0] value;
      logic               last;
   } result_word_type;

   // Ways of replaying the configured pattern into the text stream. Aliased
   // bytes keep their digit (byte modulo 3) but change value, so the hash still
   // hits while the byte compare fails.
   typedef enum int {
      COPY_EXACT,
      COPY_ONE_ALIAS,
      COPY_SCATTERED_ALIAS
   } copy_style_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   rhpm_req_if req_if ();
   rhpm_rsp_if rsp_if ();

   rolling_hash_pattern_matcher_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: our own copy of the text history, the byte counter and
   // the configuration as the block should see it.
   logic [BYTE_W-1:0]  text_history [WINDOW_DEPTH_DEF];
   int unsigned        history_head      = 0;
   logic [VALUE_W-1:0] bytes_seen        = '0;
   bit                 pattern_hash_sent = 1'b0;
   logic [LEN_W-1:0]   cfg_length        = LEN_W'(1);
   logic [CSR_W-1:0]   cfg_low           = '0;
   logic [CSR_W-1:0]   cfg_high          = '0;

   // Words the block still owes us, oldest first.
   result_word_type awaited_words [$];

   int unsigned failures        = 0;
   int unsigned bytes_sent      = 0;
   int unsigned words_checked   = 0;
   int unsigned full_matches    = 0;
   int unsigned early_stops     = 0;
   int unsigned settings_used   = 0;
   int unsigned cycle_count     = 0;
   bit          hold_requested  = 1'b0;

   // Idle stretches: each side moves between runs with random gaps and runs
   // with no gaps at all, drawing the kind of each new run at random.
   int unsigned stretch_left [2] = '{0, 0};
   bit          stretch_busy [2] = '{1'b0, 1'b0};

   function automatic int draw_gap(input int side);
      if (stretch_left[side] == 0) begin
         stretch_left[side] = $urandom_range(4, 40);
         stretch_busy[side] = ($urandom_range(0, 2) != 0);
      end
      stretch_left[side]--;
      return stretch_busy[side] ? int'($urandom_range(0, 9)) : 0;
   endfunction

   // Out-of-range lengths clamp: zero acts as one, anything above the
   // pattern store acts as the full store.
   function automatic int unsigned active_length();
      if (cfg_length == 0)
         return 1;
      if (cfg_length > MAX_PATTERN_DEF)
         return MAX_PATTERN_DEF;
      return cfg_length;
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned i);
      return BYTE_W'({cfg_high, cfg_low} >> (8 * i));
   endfunction

   // Byte k of the current window, k = 0 being the oldest.
   function automatic logic [BYTE_W-1:0] window_byte(input int unsigned span,
                                                     input int unsigned k);
      return text_history[(history_head + WINDOW_DEPTH_DEF - span + k) % WINDOW_DEPTH_DEF];
   endfunction

   // Advances the predictor by one accepted text word and queues the words the
   // block must answer with.
   function automatic void scan_text_byte(input logic [BYTE_W-1:0] text);
      int unsigned        span;
      int unsigned        target;
      int unsigned        window;
      int unsigned        weight;
      int unsigned        added;
      bit                 whole;
      logic [VALUE_W-1:0] first_pos;
      span   = active_length();
      target = 0;
      weight = 1;
      added  = 0;
      // The pattern hash is taken from the registers as they stand now, even
      // though only the very first word of the run reports it.
      for (int unsigned i = 0; i < span; i++) begin
         target += (pattern_byte(i) % 3) * weight;
         weight *= 3;
      end
      text_history[history_head] = text;
      history_head = (history_head + 1) % WINDOW_DEPTH_DEF;
      if (bytes_seen != '1)
         bytes_seen++;
      if (!pattern_hash_sent) begin
         awaited_words.push_back('{kind: KIND_HASH, value: target, last: 1'b0});
         pattern_hash_sent = 1'b1;
         added++;
      end
      // No window is looked at until it is completely filled with text.
      if (bytes_seen >= span) begin
         window = 0;
         weight = 1;
         for (int unsigned k = 0; k < span; k++) begin
            window += (window_byte(span, k) % 3) * weight;
            weight *= 3;
         end
         if (window == target) begin
            first_pos = bytes_seen - VALUE_W'(span) + 1;
            whole     = 1'b1;
            for (int unsigned k = 0; k < span; k++) begin
               awaited_words.push_back('{kind: KIND_POS, value: first_pos + k, last: 1'b0});
               added++;
               if (window_byte(span, k) != pattern_byte(k)) begin
                  whole = 1'b0;
                  break;
               end
            end
            if (whole)
               full_matches++;
            else
               early_stops++;
         end
      end
      if (added > 0)
         awaited_words[awaited_words.size() - 1].last = 1'b1;
   endfunction

   function automatic logic [BYTE_W-1:0] same_digit_byte(input logic [BYTE_W-1:0] text);
      int orig;
      int pick;
      orig = int'(text);
      pick = $urandom_range(0, 255);
      pick = pick - pick % 3 + orig % 3;
      if (pick > 255)
         pick -= 3;
      if (pick == orig)
         pick = (orig >= 3) ? orig - 3 : orig + 3;
      return BYTE_W'(pick);
   endfunction

   function automatic logic [CSR_W-1:0] pattern_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offers one text word after a drawn gap and predicts its results once the
   // block takes it. Valid stays high on return so back-to-back words flow.
   task automatic send_byte(input logic [BYTE_W-1:0] text);
      int gap;
      gap = draw_gap(TX_SIDE);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.text_byte <= text;
      do @(posedge clock); while (!req_if.ready);
      scan_text_byte(text);
      bytes_sent++;
   endtask

   // Drops valid and waits until every predicted word has come back, then
   // lets the block finish any walk that produces no further word.
   task automatic drain_results(input int settle);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (awaited_words.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_PATTERN_LENGTH: cfg_length = value[LEN_W-1:0];
         CSR_PATTERN_LOW:    cfg_low    = value;
         CSR_PATTERN_HIGH:   cfg_high   = value;
         default:            ;
      endcase
   endtask

   task automatic send_pattern_copy(input copy_style_type style);
      int unsigned       span;
      int unsigned       alias_at;
      logic [BYTE_W-1:0] text;
      span     = active_length();
      alias_at = $urandom_range(0, span - 1);
      for (int unsigned k = 0; k < span; k++) begin
         text = pattern_byte(k);
         if ((style == COPY_ONE_ALIAS && k == alias_at) ||
             (style == COPY_SCATTERED_ALIAS && $urandom_range(0, 2) == 0))
            text = same_digit_byte(text);
         send_byte(text);
      end
   endtask

   // The very first word reports the pattern hash. Pattern bytes 0..3 are
   // 0x00, 0xFF, 0x80, 0x7F; the high register and the unmapped index both
   // get all ones, and the unmapped write must change nothing.
   task automatic test_first_byte_hash();
      write_register(CSR_PATTERN_LENGTH, 64'd4);
      write_register(CSR_PATTERN_LOW, 64'h0123_4567_7F80_FF00);
      write_register(CSR_PATTERN_HIGH, '1);
      write_register(CSR_UNMAPPED, '1);
      send_byte(8'h00);
   endtask

   // Words two and three leave the window short, so nothing is compared; the
   // fourth completes a full match at positions 1 to 4.
   task automatic test_short_stream_match();
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
   endtask

   // Same digits as the pattern with the third byte altered: the hash hits and
   // the walk must stop at the altered position.
   task automatic test_alias_mismatch();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h83);
      send_byte(8'h7F);
   endtask

   // Length zero behaves as one; a length past the store behaves as sixteen.
   task automatic test_length_limits();
      drain_results(SETTLE_CYCLES);
      write_register(CSR_PATTERN_LENGTH, 64'd0);
      send_byte(8'h03);
      send_byte(8'h00);
      drain_results(SETTLE_CYCLES);
      write_register(CSR_PATTERN_LENGTH, 64'd31);
      write_register(CSR_PATTERN_LOW, {$urandom, $urandom});
      write_register(CSR_PATTERN_HIGH, {$urandom, $urandom});
      send_pattern_copy(COPY_EXACT);
   endtask

   // Random phases: each one picks a setting while the block is idle, then
   // mixes replayed patterns (exact and aliased) with noise. The text stream
   // carries on across phases, so every new length takes effect mid-stream.
   // Byte counter saturation needs 2^32 words and lies outside this run.
   task automatic test_random_settings();
      int unsigned budget;
      int unsigned phase_start;
      int unsigned noise;
      logic [CSR_W-1:0] length;
      while (bytes_sent < RANDOM_BYTES) begin
         drain_results(SETTLE_CYCLES);
         case ($urandom_range(0, 9))
            0:       length = 0;
            1:       length = $urandom_range(17, 31);
            2:       length = MAX_PATTERN_DEF;
            3:       length = $urandom_range(7, 15);
            default: length = $urandom_range(1, 6);
         endcase
         write_register(CSR_PATTERN_LOW, pattern_word());
         write_register(CSR_PATTERN_HIGH, pattern_word());
         write_register(CSR_PATTERN_LENGTH, length);
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_UNMAPPED, {$urandom, $urandom});
         settings_used++;
         budget      = (active_length() > 6) ? $urandom_range(40, 70) : $urandom_range(20, 60);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < budget) begin
            case ($urandom_range(0, 9))
               0, 1:    send_pattern_copy(COPY_EXACT);
               2, 3:    send_pattern_copy(COPY_ONE_ALIAS);
               4:       send_pattern_copy(COPY_SCATTERED_ALIAS);
               default: begin
                  noise = $urandom_range(1, 6);
                  repeat (noise) send_byte(BYTE_W'($urandom_range(0, 255)));
               end
            endcase
         end
      end
   endtask

   // A two-byte pattern replayed back to back gives a result on most words.
   // The receiver holds off for a long stretch so the block backs up into the
   // text channel; later the sender waits for every owed word mid-stream.
   task automatic test_output_backpressure();
      drain_results(SETTLE_CYCLES);
      write_register(CSR_PATTERN_LENGTH, 64'd2);
      write_register(CSR_PATTERN_LOW, {$urandom, $urandom});
      settings_used++;
      hold_requested = 1'b1;
      repeat (10) send_pattern_copy(COPY_EXACT);
      drain_results(0);
      repeat (10) send_pattern_copy(COPY_EXACT);
   endtask

   // Result side: ready follows drawn gaps, or a long hold when one is asked.
   initial begin : result_drain
      int gap;
      rsp_if.ready = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_requested) begin
            gap            = HOLD_CYCLES;
            hold_requested = 1'b0;
         end else begin
            gap = draw_gap(RX_SIDE);
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Every word leaving the block is matched against the oldest prediction.
   always @(posedge clock) begin : check_words
      result_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         words_checked++;
         if (awaited_words.size() == 0) begin
            $error("unexpected result word: kind %0d value %0d last %0d",
                   rsp_if.kind, rsp_if.value, rsp_if.last);
            failures++;
         end else begin
            want = awaited_words.pop_front();
            if (rsp_if.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_if.kind);
               failures++;
            end
            if (rsp_if.value !== want.value) begin
               $error("value: expected %0d, actual %0d", want.value, rsp_if.value);
               failures++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_if.last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("rolling_hash_pattern_matcher_top regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      csr_we           = 1'b0;
      csr_index        = CSR_PATTERN_LENGTH;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.text_byte = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_first_byte_hash();
      test_short_stream_match();
      test_alias_mismatch();
      test_length_limits();
      test_random_settings();
      test_output_backpressure();
      drain_results(SETTLE_CYCLES);
      $display("Sent %0d text words over %0d random settings; checked %0d result words.",
               bytes_sent, settings_used, words_checked);
      $display("Hash hits: %0d full matches, %0d walks cut short by a byte mismatch.",
               full_matches, early_stops);
      if (failures == 0)
         $display("rolling_hash_pattern_matcher_top regression: pass");
      else
         $display("rolling_hash_pattern_matcher_top regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/rhpm_pkg.sv
hdl/rhpm_channels.sv
hdl/rhpm_ram.sv
hdl/rolling_hash_pattern_matcher_top.sv
verif/testbench.sv
